// ===== rtl/wildcard_pattern_match_defines.svh =====
// Assertion macros shared by the wildcard pattern matcher RTL.
`ifndef WILDCARD_PATTERN_MATCH_DEFINES_SVH
`define WILDCARD_PATTERN_MATCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wildcard_pattern_match: check failed");

// Next-cycle implication, checked outside reset.
`define WPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wildcard_pattern_match: check failed");

`endif

// ===== rtl/wpm_pkg.sv =====
// Types, sizes and codes for the wildcard pattern matcher.
package wpm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int NLEV        = $clog2(MAX_PATTERN + 1);

   localparam logic [7:0] STAR_CHAR = 8'h2A;
   localparam logic [7:0] ANY_CHAR  = 8'h3F;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEXT   = 2'd2,
      OP_END    = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

   // Stored pattern as seen by the reach logic.
   typedef struct packed {
      logic [LEN_W-1:0]                 len;
      logic [MAX_PATTERN-1:0][7:0]      chars;
   } pat_type;

endpackage

// ===== rtl/wpm_reach.sv =====
// Star closure and per-character reach update for the pattern matcher.
module wpm_reach import wpm_pkg::*; (
   input  pat_type                pat,
   input  logic [MAX_PATTERN:0]   reach,
   input  logic [7:0]             text_ch,
   output logic [MAX_PATTERN:0]   eff,
   output logic [MAX_PATTERN:0]   next_reach
);

   logic [MAX_PATTERN-1:0] active;
   logic [MAX_PATTERN-1:0] is_star;

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         active[i]  = LEN_W'(i) < pat.len;
         is_star[i] = pat.chars[i] == STAR_CHAR;
      end
   end

   // Closure as a parallel prefix: generate = raw reach, propagate = live star.
   always_comb begin
      logic [MAX_PATTERN:0] g;
      logic [MAX_PATTERN:0] p;
      logic [MAX_PATTERN:0] g_n;
      logic [MAX_PATTERN:0] p_n;
      g    = reach;
      p    = '0;
      for (int j = 1; j <= MAX_PATTERN; j++) begin
         p[j] = is_star[j-1] & active[j-1];
      end
      for (int lv = 0; lv < NLEV; lv++) begin
         g_n = g;
         p_n = p;
         for (int j = (1 << lv); j <= MAX_PATTERN; j++) begin
            g_n[j] = g[j] | (p[j] & g[j - (1 << lv)]);
            p_n[j] = p[j] & p[j - (1 << lv)];
         end
         g = g_n;
         p = p_n;
      end
      eff = g;
   end

   always_comb begin
      next_reach = '0;
      for (int i = 1; i <= MAX_PATTERN; i++) begin
         if (active[i-1]) begin
            if (is_star[i-1]) begin
               next_reach[i] = eff[i];
            end else if (pat.chars[i-1] == ANY_CHAR || pat.chars[i-1] == text_ch) begin
               next_reach[i] = eff[i-1];
            end
         end
      end
   end

endmodule

// ===== rtl/wildcard_pattern_match.sv =====
// Top level of the streaming wildcard pattern matcher.
`include "wildcard_pattern_match_defines.svh"

// Wildcard pattern matcher. A pattern of up to MAX_PATTERN bytes is loaded with
// append transactions ('?' matches any one text byte, '*' any run, including
// none); text bytes are then streamed in and an end-of-text transaction returns
// one response carrying matched and the sticky pattern_overflow flag. Clear,
// append and text transactions return nothing. Clear and append restart the
// text, as does each end of text. Every request is held in the input register,
// where the work is done combinationally, so a transaction is accepted every
// cycle unless the work stage stalls, and an end-of-text result is written
// from there into the response register, which drives rsp_valid. The work
// stage stalls only when an end-of-text result meets a full, stalled response
// register. The critical path is the star closure, a prefix network of
// log2(MAX_PATTERN+1) AND/OR levels, followed by the byte compares.
module wildcard_pattern_match import wpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Input register
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;

   // Matcher state
   logic [MAX_PATTERN-1:0][7:0] chars_ff;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic [MAX_PATTERN:0]        reach_ff, reach_in;
   logic                        ovf_ff, ovf_in;

   // Response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff;

   logic                 out_free;
   logic                 proc_fire;
   logic                 is_end;
   logic                 pat_full;
   logic                 wr_char;
   pat_type              pat;
   logic [MAX_PATTERN:0] eff;
   logic [MAX_PATTERN:0] text_reach;
   logic [MAX_PATTERN:0] restart_reach;

   assign restart_reach = (MAX_PATTERN + 1)'(1);
   assign pat           = '{len: len_ff, chars: chars_ff};
   assign pat_full      = len_ff == LEN_W'(MAX_PATTERN);

   // Only end of text needs the response slot; the rest retire freely.
   assign is_end    = in_item_ff.op == OP_END;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_fire = in_valid_ff && (!is_end || out_free);
   assign req_stall = in_valid_ff && !proc_fire;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   wpm_reach u_reach (
      .pat        (pat),
      .reach      (reach_ff),
      .text_ch    (in_item_ff.ch),
      .eff        (eff),
      .next_reach (text_reach)
   );

   always_comb begin
      len_in   = len_ff;
      reach_in = reach_ff;
      ovf_in   = ovf_ff;
      wr_char  = 1'b0;
      if (proc_fire) begin
         unique case (in_item_ff.op)
            OP_CLEAR: begin
               len_in   = '0;
               ovf_in   = 1'b0;
               reach_in = restart_reach;
            end
            OP_APPEND: begin
               if (pat_full) begin
                  ovf_in = 1'b1;       // byte dropped, stored pattern kept
               end else begin
                  wr_char = 1'b1;
                  len_in  = len_ff + LEN_W'(1);
               end
               reach_in = restart_reach;
            end
            OP_TEXT: begin
               reach_in = text_reach;
            end
            OP_END: begin
               reach_in = restart_reach;
            end
            default: begin
               reach_in = reach_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (proc_fire && is_end) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         len_ff       <= '0;
         reach_ff     <= restart_reach;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         len_ff       <= len_in;
         reach_ff     <= reach_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_item_ff <= req_data;
      end
      if (wr_char) begin
         chars_ff[len_ff[IDX_W-1:0]] <= in_item_ff.ch;
      end
      if (proc_fire && is_end) begin
         rsp_item_ff.matched          <= eff[len_ff];
         rsp_item_ff.pattern_overflow <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   // Checks
   `WPM_ASSERT_NOW(a_len_in_range, clock, reset, 1'b1, len_ff <= LEN_W'(MAX_PATTERN))
   `WPM_ASSERT_NOW(a_ovf_only_full, clock, reset, ovf_ff, pat_full)
   `WPM_ASSERT_NEXT(a_text_clears_root, clock, reset, proc_fire && in_item_ff.op == OP_TEXT, !reach_ff[0])
   `WPM_ASSERT_NEXT(a_held_item_kept, clock, reset, in_valid_ff && req_stall, in_valid_ff)

endmodule
